/* design/bai_pkg.sv */
`timescale 1ns / 1ps

package bai_pkg;

	typedef enum logic [1:0] {
		MODE_RECORD = 2'd0,
		MODE_APPLY  = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_STATUS = 2'd3
	} mode_t;

	localparam logic [1:0] CFG_RECORD_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_PLAY_ENABLE    = 2'd1;
	localparam logic [1:0] CFG_REPLACE_WINDOW = 2'd2;

	localparam logic [15:0] WINDOW_RESET = 16'd655;
	localparam logic [14:0] FREQ_MIN     = 15'd20;
	localparam logic [14:0] FREQ_MAX     = 15'd32767;

	typedef struct packed {
		mode_t              mode;
		logic [2:0]         band;
		logic [15:0]        loop_pos;
		logic [14:0]        freq_hz;
		logic signed [15:0] gain_db;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         band_out;
		logic               has_value;
		logic [14:0]        freq_out;
		logic signed [15:0] gain_out;
		logic               any_data;
		logic               last;
	} out_item_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(2^-k) in Q1.30, built by repeated truncating square roots
	function automatic logic [31:0] exp_root(int k);
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int i = 0; i < 16; i++) begin
			if (i < k) r = isqrt64(r << 30);
		end
		return r[31:0];
	endfunction

endpackage

/* design/breakpoint_automation_interpolator.sv */
`timescale 1ns / 1ps

// Breakpoint automation interpolator. Each band keeps a sorted table of
// (position, frequency, gain) breakpoints in one shared single-port-write
// memory; all arithmetic runs through one 32x32 multiplier and one
// bit-serial divider under a sequencer, so the block takes one item at a
// time and holds in_stall high while it works. An enabled record item
// makes a replace pass over the stored points, then, if there is room,
// moves points to open the insert slot. An apply item visits each band
// in turn: an empty or disabled band gives no value, a position at or
// beyond an edge takes that edge point's values, and an interior position
// is interpolated on the segment that ends at point u (at most n - 1 in a
// band of n points): two divisions, two log2 squaring loops and an exp2
// product chain dominate. Results leave through an output register, so
// the next item is accepted while the last result still waits. There is
// no clearing pass: each band's fill count bounds what is read.
module breakpoint_automation_interpolator
	import bai_pkg::*;
#(
	parameter int BAND_COUNT = 8,
	parameter int MAX_POINTS = 64,
	parameter int POS_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int BW    = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int DEPTH = BAND_COUNT * MAX_POINTS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [4:0]    BAND_LIM  = 5'(BAND_COUNT);
	localparam logic [BW-1:0] BAND_LAST = BW'(BAND_COUNT - 1);
	localparam logic [CW-1:0] CNT_FULL  = CW'(MAX_POINTS);

	localparam logic [31:0] EXP_TAB [16] = '{
		exp_root(1),  exp_root(2),  exp_root(3),  exp_root(4),
		exp_root(5),  exp_root(6),  exp_root(7),  exp_root(8),
		exp_root(9),  exp_root(10), exp_root(11), exp_root(12),
		exp_root(13), exp_root(14), exp_root(15), exp_root(16)
	};

	typedef struct packed {
		logic [POS_BITS-1:0] pos;
		logic [14:0]         freq;
		logic signed [15:0]  gain;
	} point_t;

	typedef enum logic [4:0] {
		S_IDLE, S_EMIT,
		S_C_RD, S_C_EV, S_SH, S_SH_CHK, S_SH_WR, S_INS,
		S_A_BAND, S_A_EV0, S_A_EVL, S_A_SCAN, S_A_EVS,
		S_G_MUL, S_DIV_INIT, S_DIV, S_DIV_FIN,
		S_LOG_INIT, S_LOG_MUL, S_LOG_EV, S_L_MUL,
		S_EXP_INIT, S_EXP_MUL, S_EXP_EV, S_EXP_FIN
	} state_t;

	state_t state_q;

	point_t mem [DEPTH];
	point_t rd_q;
	logic          mem_re, mem_we;
	logic [AW-1:0] mem_raddr, mem_waddr;
	point_t        mem_wdata;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_q;

	logic                rec_en_q, play_en_q;
	logic [15:0]         win_q;
	logic [CW-1:0]       cnt_q [BAND_COUNT];
	point_t              new_q;
	logic [BW-1:0]       band_q;
	logic [CW-1:0]       n_q, idx_q, j_q, k_q;
	point_t              p0_q, p1_q;
	out_item_t           res_q, out_q;
	logic                out_valid_q;

	logic [47:0] num_q;
	logic [25:0] rem_q, den_q;
	logic [5:0]  div_cnt_q;
	logic        div_gain_q, neg_q;
	logic [31:0] m_q;
	logic [3:0]  e_q;
	logic [15:0] frac_q;
	logic [3:0]  step_q;
	logic        lsel_q;
	logic [19:0] l0_q, l1_q, l_q;
	logic [31:0] acc_q;
	logic [15:0] gres_q;

	logic                any_data_w;
	logic [23:0]         pos_wide;
	logic [POS_BITS-1:0] pos_w, diff_w, d_w, span_w;
	logic                keep_w, edge0_w;
	logic signed [16:0]  gd_w;
	logic [16:0]         gd_mag_w;
	logic signed [20:0]  dl_w;
	logic [20:0]         dl_mag_w;
	logic [14:0]         fx_w;
	logic [3:0]          fe_w;
	logic [26:0]         div_t_w;
	logic [33:0]         sq_w;
	logic [45:0]         exp_sh_w;
	logic [46:0]         exp_v_w;

	function automatic logic [AW-1:0] addr_of(logic [BW-1:0] b, logic [CW-1:0] i);
		return AW'(AW'(b) * AW'(MAX_POINTS)) + AW'(i[IW-1:0]);
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign pos_wide = 24'(in_data.loop_pos);
	assign pos_w    = pos_wide[POS_BITS-1:0];

	always_comb begin
		any_data_w = 1'b0;
		for (int b = 0; b < BAND_COUNT; b++) begin
			if (cnt_q[b] != '0) any_data_w = 1'b1;
		end
	end

	assign diff_w  = (rd_q.pos > new_q.pos) ? rd_q.pos - new_q.pos : new_q.pos - rd_q.pos;
	assign keep_w  = !(24'(diff_w) < 24'(win_q));
	assign edge0_w = (n_q == CW'(1)) || (new_q.pos <= rd_q.pos);

	assign d_w      = new_q.pos - p0_q.pos;
	assign span_w   = p1_q.pos - p0_q.pos;
	assign gd_w     = 17'(p1_q.gain) - 17'(p0_q.gain);
	assign gd_mag_w = gd_w[16] ? 17'(-gd_w) : 17'(gd_w);
	assign dl_w     = $signed({1'b0, l1_q}) - $signed({1'b0, l0_q});
	assign dl_mag_w = dl_w[20] ? 21'(-dl_w) : 21'(dl_w);

	always_comb begin
		fx_w = lsel_q ? p1_q.freq : p0_q.freq;
		if (fx_w < FREQ_MIN) fx_w = FREQ_MIN;
		fe_w = '0;
		for (int i = 0; i < 15; i++) begin
			if (fx_w[i]) fe_w = 4'(i);
		end
	end

	assign div_t_w  = {rem_q, num_q[47]};
	assign sq_w     = mul_q[63:30];
	assign exp_sh_w = 46'(acc_q) << l_q[19:16];
	assign exp_v_w  = (47'(exp_sh_w) + (47'd1 << 29)) >> 30;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_G_MUL: begin
				mul_a = 32'(d_w);
				mul_b = 32'(gd_mag_w);
			end
			S_L_MUL: begin
				mul_a = 32'(d_w);
				mul_b = 32'(dl_mag_w);
			end
			S_LOG_MUL: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			S_EXP_MUL: begin
				mul_a = acc_q;
				mul_b = EXP_TAB[step_q];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = new_q;
		case (state_q)
			S_C_RD: begin
				mem_re    = (idx_q != n_q);
				mem_raddr = addr_of(band_q, idx_q);
			end
			S_C_EV: begin
				mem_we    = keep_w;
				mem_waddr = addr_of(band_q, j_q);
				mem_wdata = rd_q;
			end
			S_SH_CHK: begin
				mem_re    = (idx_q != k_q);
				mem_raddr = addr_of(band_q, idx_q - CW'(1));
			end
			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(band_q, idx_q);
				mem_wdata = rd_q;
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(band_q, k_q);
			end
			S_A_BAND: begin
				mem_re    = 1'b1;
				mem_raddr = addr_of(band_q, '0);
			end
			S_A_EV0: begin
				mem_re    = 1'b1;
				mem_raddr = addr_of(band_q, n_q - CW'(1));
			end
			S_A_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = addr_of(band_q, idx_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rec_en_q    <= 1'b0;
			play_en_q   <= 1'b0;
			win_q       <= WINDOW_RESET;
			out_valid_q <= 1'b0;
			for (int b = 0; b < BAND_COUNT; b++) cnt_q[b] <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_RECORD_ENABLE:  rec_en_q  <= cfg_data[0];
					CFG_PLAY_ENABLE:    play_en_q <= cfg_data[0];
					CFG_REPLACE_WINDOW: win_q     <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_EMIT) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						new_q.pos  <= pos_w;
						new_q.freq <= in_data.freq_hz;
						new_q.gain <= in_data.gain_db;
						band_q     <= (in_data.mode == MODE_APPLY) ? '0 : BW'(in_data.band);
						idx_q      <= '0;
						j_q        <= '0;
						k_q        <= '0;
						case (in_data.mode)
							MODE_RECORD: begin
								if (rec_en_q && (5'(in_data.band) < BAND_LIM)) begin
									n_q     <= cnt_q[BW'(in_data.band)];
									state_q <= S_C_RD;
								end
							end
							MODE_CLEAR: begin
								for (int b = 0; b < BAND_COUNT; b++) cnt_q[b] <= '0;
							end
							MODE_STATUS: begin
								res_q   <= '{band_out: 3'd0, has_value: 1'b0, freq_out: 15'd0,
									gain_out: 16'sd0, any_data: 1'b0, last: 1'b1};
								state_q <= S_EMIT;
							end
							MODE_APPLY: begin
								state_q <= S_A_BAND;
							end
							default: ;
						endcase
					end
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= '{band_out: res_q.band_out, has_value: res_q.has_value,
							freq_out: res_q.freq_out, gain_out: res_q.gain_out,
							any_data: any_data_w, last: res_q.last};
						out_valid_q <= 1'b1;
						if (res_q.last) begin
							state_q <= S_IDLE;
						end else begin
							band_q  <= band_q + BW'(1);
							state_q <= S_A_BAND;
						end
					end
				end
				S_C_RD: begin
					state_q <= (idx_q == n_q) ? S_SH : S_C_EV;
				end
				S_C_EV: begin
					if (keep_w) begin
						j_q <= j_q + CW'(1);
						if (rd_q.pos < new_q.pos) k_q <= k_q + CW'(1);
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_C_RD;
				end
				S_SH: begin
					if (j_q == CNT_FULL) begin
						cnt_q[band_q] <= j_q;
						state_q       <= S_IDLE;
					end else begin
						idx_q   <= j_q;
						state_q <= S_SH_CHK;
					end
				end
				S_SH_CHK: begin
					state_q <= (idx_q == k_q) ? S_INS : S_SH_WR;
				end
				S_SH_WR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SH_CHK;
				end
				S_INS: begin
					cnt_q[band_q] <= j_q + CW'(1);
					state_q       <= S_IDLE;
				end
				S_A_BAND: begin
					n_q   <= cnt_q[band_q];
					res_q <= '{band_out: 3'(band_q), has_value: 1'b0, freq_out: 15'd0,
						gain_out: 16'sd0, any_data: 1'b0, last: (band_q == BAND_LAST)};
					if (!play_en_q || cnt_q[band_q] == '0) state_q <= S_EMIT;
					else state_q <= S_A_EV0;
				end
				S_A_EV0: begin
					p0_q <= rd_q;
					if (edge0_w) begin
						res_q.has_value <= 1'b1;
						res_q.freq_out  <= rd_q.freq;
						res_q.gain_out  <= rd_q.gain;
						state_q         <= S_EMIT;
					end else begin
						state_q <= S_A_EVL;
					end
				end
				S_A_EVL: begin
					if (new_q.pos >= rd_q.pos) begin
						res_q.has_value <= 1'b1;
						res_q.freq_out  <= rd_q.freq;
						res_q.gain_out  <= rd_q.gain;
						state_q         <= S_EMIT;
					end else begin
						idx_q   <= CW'(1);
						state_q <= S_A_SCAN;
					end
				end
				S_A_SCAN: begin
					state_q <= S_A_EVS;
				end
				S_A_EVS: begin
					if (new_q.pos < rd_q.pos) begin
						p1_q    <= rd_q;
						state_q <= S_G_MUL;
					end else begin
						p0_q    <= rd_q;
						idx_q   <= idx_q + CW'(1);
						state_q <= S_A_SCAN;
					end
				end
				S_G_MUL: begin
					neg_q      <= gd_w[16];
					div_gain_q <= 1'b1;
					state_q    <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					num_q     <= (48'(mul_q) << 1) + 48'(span_w);
					den_q     <= 26'(span_w) << 1;
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (div_t_w >= {1'b0, den_q}) begin
						rem_q <= 26'(div_t_w - {1'b0, den_q});
						num_q <= {num_q[46:0], 1'b1};
					end else begin
						rem_q <= div_t_w[25:0];
						num_q <= {num_q[46:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd47) state_q <= S_DIV_FIN;
				end
				S_DIV_FIN: begin
					if (div_gain_q) begin
						gres_q  <= neg_q ? p0_q.gain - num_q[15:0] : p0_q.gain + num_q[15:0];
						lsel_q  <= 1'b0;
						state_q <= S_LOG_INIT;
					end else begin
						l_q     <= neg_q ? l0_q - num_q[19:0] : l0_q + num_q[19:0];
						state_q <= S_EXP_INIT;
					end
				end
				S_LOG_INIT: begin
					m_q     <= 32'(fx_w) << (5'd30 - 5'(fe_w));
					e_q     <= fe_w;
					frac_q  <= '0;
					step_q  <= '0;
					state_q <= S_LOG_MUL;
				end
				S_LOG_MUL: begin
					state_q <= S_LOG_EV;
				end
				S_LOG_EV: begin
					m_q    <= sq_w[31] ? sq_w[32:1] : sq_w[31:0];
					frac_q <= {frac_q[14:0], sq_w[31]};
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						if (!lsel_q) begin
							l0_q    <= {e_q, frac_q[14:0], sq_w[31]};
							lsel_q  <= 1'b1;
							state_q <= S_LOG_INIT;
						end else begin
							l1_q    <= {e_q, frac_q[14:0], sq_w[31]};
							state_q <= S_L_MUL;
						end
					end else begin
						state_q <= S_LOG_MUL;
					end
				end
				S_L_MUL: begin
					neg_q      <= dl_w[20];
					div_gain_q <= 1'b0;
					state_q    <= S_DIV_INIT;
				end
				S_EXP_INIT: begin
					acc_q   <= 32'd1 << 30;
					step_q  <= '0;
					state_q <= S_EXP_MUL;
				end
				S_EXP_MUL: begin
					state_q <= S_EXP_EV;
				end
				S_EXP_EV: begin
					if (l_q[~step_q]) acc_q <= mul_q[61:30];
					step_q <= step_q + 4'd1;
					state_q <= (step_q == 4'd15) ? S_EXP_FIN : S_EXP_MUL;
				end
				S_EXP_FIN: begin
					res_q.has_value <= 1'b1;
					res_q.gain_out  <= gres_q;
					res_q.freq_out  <= (l_q[19:16] > 4'd14 || exp_v_w > 47'(FREQ_MAX))
						? FREQ_MAX : exp_v_w[14:0];
					state_q <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/bai_checker.sv */
`timescale 1ns / 1ps

module bai_checker
	import bai_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_apply_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.mode == MODE_APPLY |=> in_stall)
		else $error("apply beat did not make the block busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> in_stall)
		else $error("input taken while apply results remain");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.has_value |-> out_data.freq_out == 15'd0
			&& out_data.gain_out == 16'sd0)
		else $error("result without value carries data");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration beat refused");

endmodule

bind breakpoint_automation_interpolator bai_checker u_bai_checker (.*);

/* bench/breakpoint_automation_interpolator_test.sv */
`timescale 1ns / 1ps

module breakpoint_automation_interpolator_test;
	import bai_pkg::*;

	localparam int BANDS    = 8;
	localparam int DEPTH    = 64;
	localparam int SETTLE   = 400;
	localparam int HOLD_LEN = 400;
	localparam int WD_LIMIT = 30000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	breakpoint_automation_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [15:0] pt_pos [BANDS][DEPTH];
	logic [14:0] pt_freq [BANDS][DEPTH];
	int          pt_gain [BANDS][DEPTH];
	int          pt_count [BANDS];
	bit          rec_en;
	bit          play_en;
	logic [15:0] window;

	out_item_t   band_values_q[$];
	int          err_count;
	int          mism_count;
	bit          idle_on;
	bit          hold_req;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint round_div(longint n, longint d);
		if (n >= 0) return (2 * n + d) / (2 * d);
		return -((-2 * n + d) / (2 * d));
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] log2_fix(logic [31:0] x);
		int          e;
		logic [63:0] m;
		logic [31:0] frac;
		e = 0;
		frac = '0;
		while ((x >> (e + 1)) != 0) e++;
		m = 64'(x) << (30 - e);
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (32'(e) << 16) | frac;
	endfunction

	function automatic int exp2_hz(logic [31:0] l);
		int          e;
		logic [63:0] r;
		logic [63:0] acc;
		logic [63:0] v;
		e = l >> 16;
		r = 64'd1 << 31;
		acc = 64'd1 << 30;
		if (e > 14) return 32767;
		for (int k = 1; k <= 16; k++) begin
			r = int_sqrt(r << 30);
			if (l[16 - k]) acc = (acc * r) >> 30;
		end
		v = ((acc << e) + (64'd1 << 29)) >> 30;
		return (v > 32767) ? 32767 : int'(v);
	endfunction

	function automatic bit band_value(int b, logic [15:0] pos, output int f, output int g);
		int     n;
		longint d;
		longint span;
		longint l0;
		longint l1;
		int     f0;
		int     f1;
		n = pt_count[b];
		f = 0;
		g = 0;
		if (n == 0) return 0;
		if (n == 1 || pos <= pt_pos[b][0]) begin
			f = pt_freq[b][0];
			g = pt_gain[b][0];
			return 1;
		end
		if (pos >= pt_pos[b][n-1]) begin
			f = pt_freq[b][n-1];
			g = pt_gain[b][n-1];
			return 1;
		end
		for (int i = 0; i + 1 < n; i++) begin
			if (pos >= pt_pos[b][i] && pos < pt_pos[b][i+1]) begin
				d = longint'(pos) - longint'(pt_pos[b][i]);
				span = longint'(pt_pos[b][i+1]) - longint'(pt_pos[b][i]);
				f0 = (pt_freq[b][i] < 20) ? 20 : pt_freq[b][i];
				f1 = (pt_freq[b][i+1] < 20) ? 20 : pt_freq[b][i+1];
				l0 = log2_fix(f0);
				l1 = log2_fix(f1);
				f = exp2_hz(32'(l0 + round_div(d * (l1 - l0), span)));
				g = int'(longint'(pt_gain[b][i]) +
					round_div(d * (longint'(pt_gain[b][i+1]) - longint'(pt_gain[b][i])), span));
				return 1;
			end
		end
		return 0;
	endfunction

	task automatic store_point(in_item_t it);
		int b;
		int j;
		int k;
		int diff;
		b = it.band;
		j = 0;
		for (int i = 0; i < pt_count[b]; i++) begin
			diff = (pt_pos[b][i] > it.loop_pos) ? pt_pos[b][i] - it.loop_pos
				: it.loop_pos - pt_pos[b][i];
			if (!(diff < window)) begin
				pt_pos[b][j] = pt_pos[b][i];
				pt_freq[b][j] = pt_freq[b][i];
				pt_gain[b][j] = pt_gain[b][i];
				j++;
			end
		end
		if (j < DEPTH) begin
			k = 0;
			while (k < j && pt_pos[b][k] < it.loop_pos) k++;
			for (int i = j; i > k; i--) begin
				pt_pos[b][i] = pt_pos[b][i-1];
				pt_freq[b][i] = pt_freq[b][i-1];
				pt_gain[b][i] = pt_gain[b][i-1];
			end
			pt_pos[b][k] = it.loop_pos;
			pt_freq[b][k] = it.freq_hz;
			pt_gain[b][k] = it.gain_db;
			j++;
		end
		pt_count[b] = j;
	endtask

	task automatic predict_item(in_item_t it);
		bit        anyd;
		bit        hv;
		int        f;
		int        g;
		out_item_t o;
		anyd = 0;
		for (int b = 0; b < BANDS; b++) if (pt_count[b] != 0) anyd = 1;
		case (it.mode)
			MODE_RECORD: if (rec_en) store_point(it);
			MODE_CLEAR: for (int b = 0; b < BANDS; b++) pt_count[b] = 0;
			MODE_STATUS: begin
				o = '0;
				o.any_data = anyd;
				o.last = 1'b1;
				band_values_q = {band_values_q, o};
			end
			default: begin
				for (int b = 0; b < BANDS; b++) begin
					hv = play_en && band_value(b, it.loop_pos, f, g);
					o.band_out = b;
					o.has_value = hv;
					o.freq_out = hv ? 15'(f) : '0;
					o.gain_out = hv ? 16'(g) : '0;
					o.any_data = anyd;
					o.last = (b == BANDS - 1);
					band_values_q = {band_values_q, o};
				end
			end
		endcase
	endtask

	task automatic send_item(in_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		predict_item(it);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (band_values_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RECORD_ENABLE: rec_en = val[0];
			CFG_PLAY_ENABLE: play_en = val[0];
			CFG_REPLACE_WINDOW: window = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic in_item_t make_item(mode_t m, int b, int pos, int f, int g);
		in_item_t it;
		it.mode = m;
		it.band = 3'(b);
		it.loop_pos = 16'(pos);
		it.freq_hz = 15'(f);
		it.gain_db = 16'(g);
		return it;
	endfunction

	function automatic in_item_t random_item();
		int     sel;
		mode_t  m;
		sel = $urandom_range(0, 99);
		if (sel < 55) m = MODE_RECORD;
		else if (sel < 85) m = MODE_APPLY;
		else if (sel < 89) m = MODE_CLEAR;
		else m = MODE_STATUS;
		return make_item(m, $urandom_range(0, 7), $urandom_range(0, 65535),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 32767),
			$urandom_range(0, 65535));
	endfunction

	task automatic test_reset_state();
		send_item(make_item(MODE_STATUS, 0, 0, 0, 0));
		send_item(make_item(MODE_RECORD, 1, 100, 1000, 256));
		send_item(make_item(MODE_APPLY, 0, 100, 0, 0));
	endtask

	task automatic test_directed();
		write_reg(CFG_RECORD_ENABLE, 16'd1);
		write_reg(CFG_PLAY_ENABLE, 16'd1);
		send_item(make_item(MODE_RECORD, 0, 0, 0, -32768));
		send_item(make_item(MODE_RECORD, 0, 65535, 24000, 32767));
		send_item(make_item(MODE_RECORD, 7, 30000, 32767, -1));
		send_item(make_item(MODE_RECORD, 3, 1000, 5, 100));
		send_item(make_item(MODE_RECORD, 3, 9000, 19, -100));
		send_item(make_item(MODE_STATUS, 0, 0, 0, 0));
		send_item(make_item(MODE_APPLY, 0, 0, 0, 0));
		send_item(make_item(MODE_APPLY, 0, 65535, 0, 0));
		send_item(make_item(MODE_APPLY, 0, 32768, 0, 0));
		send_item(make_item(MODE_APPLY, 0, 5000, 0, 0));
		send_item(make_item(MODE_RECORD, 0, 300, 50, 0));
		send_item(make_item(MODE_APPLY, 0, 200, 0, 0));
		write_reg(CFG_REPLACE_WINDOW, 16'd0);
		send_item(make_item(MODE_RECORD, 2, 4000, 440, 512));
		send_item(make_item(MODE_RECORD, 2, 4000, 880, -512));
		send_item(make_item(MODE_APPLY, 0, 4000, 0, 0));
		write_reg(CFG_REPLACE_WINDOW, 16'd65535);
		send_item(make_item(MODE_RECORD, 0, 32768, 1000, 0));
		send_item(make_item(MODE_APPLY, 0, 1, 0, 0));
		write_reg(CFG_RECORD_ENABLE, 16'd0);
		send_item(make_item(MODE_RECORD, 4, 10, 10, 10));
		write_reg(CFG_PLAY_ENABLE, 16'd0);
		send_item(make_item(MODE_APPLY, 0, 10, 0, 0));
		send_item(make_item(MODE_CLEAR, 0, 0, 0, 0));
		send_item(make_item(MODE_STATUS, 0, 0, 0, 0));
	endtask

	task automatic test_full_table();
		write_reg(CFG_RECORD_ENABLE, 16'd1);
		write_reg(CFG_PLAY_ENABLE, 16'd1);
		write_reg(CFG_REPLACE_WINDOW, 16'd0);
		for (int i = 0; i < DEPTH + 3; i++)
			send_item(make_item(MODE_RECORD, 5, $urandom_range(0, 65535),
				$urandom_range(0, 32767), $urandom_range(0, 65535)));
		send_item(make_item(MODE_APPLY, 0, $urandom_range(0, 65535), 0, 0));
		send_item(make_item(MODE_APPLY, 0, 0, 0, 0));
	endtask

	task automatic test_random_phase(logic [15:0] win, bit rec, bit play, int count);
		write_reg(CFG_REPLACE_WINDOW, win);
		write_reg(CFG_RECORD_ENABLE, 16'(rec));
		write_reg(CFG_PLAY_ENABLE, 16'(play));
		for (int i = 0; i < count; i++) send_item(random_item());
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++)
			send_item(make_item(MODE_APPLY, 0, $urandom_range(0, 65535), 0, 0));
		drain();
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			if (band_values_q.size() == 0) begin
				err_count++;
				if (mism_count++ < 10) $display("unexpected beat %h", out_data);
			end else begin
				want = band_values_q.pop_front();
				if (out_data.band_out !== want.band_out || out_data.has_value !== want.has_value
					|| out_data.freq_out !== want.freq_out
					|| out_data.gain_out !== want.gain_out
					|| out_data.any_data !== want.any_data || out_data.last !== want.last) begin
					err_count++;
					if (mism_count++ < 10)
						$display("mismatch: expected band %0d hv %0d f %0d g %0d any %0d last %0d, got band %0d hv %0d f %0d g %0d any %0d last %0d",
							want.band_out, want.has_value, want.freq_out, want.gain_out,
							want.any_data, want.last, out_data.band_out, out_data.has_value,
							out_data.freq_out, out_data.gain_out, out_data.any_data,
							out_data.last);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else if (++quiet >= WD_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rec_en = 0;
		play_en = 0;
		window = WINDOW_RESET;
		err_count = 0;
		mism_count = 0;
		idle_on = 1;
		hold_req = 0;
		for (int b = 0; b < BANDS; b++) pt_count[b] = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed();
		test_full_table();
		test_random_phase(16'd655, 1, 1, 90);
		test_backpressure();
		test_random_phase(16'd0, 1, 1, 80);
		test_random_phase(16'($urandom_range(1, 8000)), 1, 1, 70);
		test_random_phase(16'd65535, 1, 1, 30);
		test_random_phase(16'd2000, 0, 1, 20);
		test_random_phase(16'd300, 1, 0, 20);
		idle_on = 0;
		test_random_phase(16'd1000, 1, 1, 40);

		drain();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
